>>> rtl/core/gtc_pkg.sv
package gtc_pkg;

  // Fixed field widths
  localparam int ID_W  = 10;
  localparam int CNT_W = 26;
  // Wide enough to hold any node count in range
  localparam int CMP_W = 17;

  localparam int DEF_NODES   = 1024;
  localparam int DEF_MAX_DEG = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Command codes
  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_COUNT  = 1'b1
  } func_t;

  typedef struct packed {
    func_t           func;
    logic [ID_W-1:0] src_node;
    logic [ID_W-1:0] dst_node;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] triangle_count;
    logic             overflow;
  } result_t;

  // Walker status back to the control
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] total;
  } walk_stat_t;

endpackage

>>> rtl/core/gtc_stream_if.sv
interface gtc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/gtc_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module gtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gtc_walk.sv
// Walk sequencer: nested scan n -> a -> b -> c over the two memories.
// Each memory read has an issue state and a data state.
module gtc_walk #(
  parameter int NODES   = gtc_pkg::DEF_NODES,
  parameter int MAX_DEG = gtc_pkg::DEF_MAX_DEG,
  localparam int NODE_W = $clog2(NODES),
  localparam int LEN_W  = $clog2(MAX_DEG + 1),
  localparam int ADDR_W = $clog2(NODES * MAX_DEG)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [LEN_W-1:0]         len_rdata,
  input  logic [gtc_pkg::ID_W-1:0] adj_rdata,
  output logic [NODE_W-1:0]        len_raddr,
  output logic [ADDR_W-1:0]        adj_raddr,
  output gtc_pkg::walk_stat_t      stat
);

  localparam int ID_W  = gtc_pkg::ID_W;
  localparam int CMP_W = gtc_pkg::CMP_W;
  localparam int CNT_W = gtc_pkg::CNT_W;
  localparam logic [CMP_W-1:0]  NODES_C = CMP_W'(NODES);
  localparam logic [NODE_W-1:0] LAST_N  = NODE_W'(NODES - 1);
  localparam logic [ADDR_W-1:0] DEG_C   = ADDR_W'(MAX_DEG);

  typedef enum logic [3:0] {
    W_IDLE, W_N_RD, W_N_DAT, W_I, W_I_DAT, W_A_DAT,
    W_J, W_J_DAT, W_B_DAT, W_K, W_K_DAT, W_DONE
  } wstate_t;

  wstate_t           state;
  logic [NODE_W-1:0] n;
  logic [ID_W-1:0]   a;
  logic [LEN_W-1:0]  dn, da, db;
  logic [LEN_W-1:0]  i, j, k;
  logic [ADDR_W-1:0] base_n, base_a, base_b;
  logic [CNT_W-1:0]  total;
  logic              done;

  function automatic logic id_ok(input logic [ID_W-1:0] id);
    return CMP_W'(id) < NODES_C;
  endfunction

  function automatic logic is_n(input logic [ID_W-1:0] id, input logic [NODE_W-1:0] nd);
    return CMP_W'(id) == CMP_W'(nd);
  endfunction

  // Read addresses
  always_comb begin
    len_raddr = n;
    adj_raddr = base_n + ADDR_W'(i);
    case (state)
      W_I_DAT: len_raddr = NODE_W'(adj_rdata);
      W_J_DAT: len_raddr = NODE_W'(adj_rdata);
      W_J:     adj_raddr = base_a + ADDR_W'(j);
      W_K:     adj_raddr = base_b + ADDR_W'(k);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            n     <= '0;
            total <= '0;
            state <= W_N_RD;
          end
        end
        W_N_RD: begin
          base_n <= ADDR_W'(n) * DEG_C;
          state  <= W_N_DAT;
        end
        W_N_DAT: begin
          dn    <= len_rdata;
          i     <= '0;
          state <= W_I;
        end
        W_I: begin
          if (i == dn) begin
            if (n == LAST_N) begin
              state <= W_DONE;
            end else begin
              n     <= n + 1'b1;
              state <= W_N_RD;
            end
          end else begin
            state <= W_I_DAT;
          end
        end
        // Neighbor a: skip self loops and ids with no list
        W_I_DAT: begin
          a <= adj_rdata;
          if (is_n(adj_rdata, n) || !id_ok(adj_rdata)) begin
            i     <= i + 1'b1;
            state <= W_I;
          end else begin
            base_a <= ADDR_W'(NODE_W'(adj_rdata)) * DEG_C;
            state  <= W_A_DAT;
          end
        end
        W_A_DAT: begin
          da    <= len_rdata;
          j     <= '0;
          state <= W_J;
        end
        W_J: begin
          if (j == da) begin
            i     <= i + 1'b1;
            state <= W_I;
          end else begin
            state <= W_J_DAT;
          end
        end
        // Neighbor b: skip n, a and ids with no list
        W_J_DAT: begin
          if (is_n(adj_rdata, n) || adj_rdata == a || !id_ok(adj_rdata)) begin
            j     <= j + 1'b1;
            state <= W_J;
          end else begin
            base_b <= ADDR_W'(NODE_W'(adj_rdata)) * DEG_C;
            state  <= W_B_DAT;
          end
        end
        W_B_DAT: begin
          db    <= len_rdata;
          k     <= '0;
          state <= W_K;
        end
        W_K: begin
          if (k == db) begin
            j     <= j + 1'b1;
            state <= W_J;
          end else begin
            state <= W_K_DAT;
          end
        end
        // Closing edge back to n, saturating count
        W_K_DAT: begin
          if (is_n(adj_rdata, n) && total != gtc_pkg::CNT_MAX) begin
            total <= total + 1'b1;
          end
          k     <= k + 1'b1;
          state <= W_K;
        end
        W_DONE: begin
          done  <= 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  assign stat = '{done: done, total: total};

endmodule

>>> rtl/core/graph_triangle_counter.sv
// Append item: length read, then write; no new item is taken until the write is done.
// Count item: the walker scans every node and its nested lists, with an issue and a data
// step per list entry read at every level; then the result and a length clear pass over
// all NODES entries, one length entry per cycle, before the next item is taken.
// Reset (synchronous) starts the same clear pass; no item is taken
// until it ends. The adjacency memory itself is never cleared.
module graph_triangle_counter #(
  parameter int NODES   = gtc_pkg::DEF_NODES,
  parameter int MAX_DEG = gtc_pkg::DEF_MAX_DEG
) (
  input logic             clk,
  input logic             rst,
  gtc_stream_if.sink      cmd,
  gtc_stream_if.source    result
);

  localparam int ID_W   = gtc_pkg::ID_W;
  localparam int CMP_W  = gtc_pkg::CMP_W;
  localparam int NODE_W = $clog2(NODES);
  localparam int LEN_W  = $clog2(MAX_DEG + 1);
  localparam int ADDR_W = $clog2(NODES * MAX_DEG);
  localparam logic [CMP_W-1:0]  NODES_C = CMP_W'(NODES);
  localparam logic [NODE_W-1:0] LAST_N  = NODE_W'(NODES - 1);
  localparam logic [LEN_W-1:0]  FULL    = LEN_W'(MAX_DEG);
  localparam logic [ADDR_W-1:0] DEG_C   = ADDR_W'(MAX_DEG);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_APPEND, S_WALK, S_EMIT
  } state_t;

  state_t              state;
  logic [NODE_W-1:0]   clr_cnt;
  logic [NODE_W-1:0]   src_q;
  logic [ID_W-1:0]     dst_q;
  logic [ADDR_W-1:0]   base_src;
  logic                dropped;
  logic [gtc_pkg::CNT_W-1:0] total_q;
  logic                res_valid;
  gtc_pkg::result_t    res_data;

  gtc_pkg::cmd_t       cmd_d;
  logic                accept;
  logic                walk_start;
  gtc_pkg::walk_stat_t walk_stat;
  logic [NODE_W-1:0]   walk_len_raddr;
  logic [ADDR_W-1:0]   walk_adj_raddr;

  logic                len_we;
  logic [NODE_W-1:0]   len_waddr;
  logic [LEN_W-1:0]    len_wdata;
  logic [NODE_W-1:0]   len_raddr;
  logic [LEN_W-1:0]    len_rdata;
  logic                adj_we;
  logic [ADDR_W-1:0]   adj_waddr;
  logic [ID_W-1:0]     adj_rdata;

  assign cmd_d      = cmd.data;
  assign cmd.ready  = (state == S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign walk_start = accept && (cmd_d.func == gtc_pkg::FUNC_COUNT);

  assign result.valid = res_valid;
  assign result.data  = res_data;

  // Length memory port muxing: clear pass, append update, walker / append lookup
  always_comb begin
    len_we    = 1'b0;
    len_waddr = src_q;
    len_wdata = len_rdata + 1'b1;
    adj_we    = 1'b0;
    adj_waddr = base_src + ADDR_W'(len_rdata);
    len_raddr = (state == S_WALK) ? walk_len_raddr : NODE_W'(cmd_d.src_node);
    case (state)
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_cnt;
        len_wdata = '0;
      end
      S_APPEND: begin
        len_we = (len_rdata != FULL);
        adj_we = (len_rdata != FULL);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_N) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end
        end
        S_IDLE: begin
          src_q    <= NODE_W'(cmd_d.src_node);
          dst_q    <= cmd_d.dst_node;
          base_src <= ADDR_W'(NODE_W'(cmd_d.src_node)) * DEG_C;
          if (accept) begin
            if (cmd_d.func == gtc_pkg::FUNC_COUNT) begin
              state <= S_WALK;
            end else if (CMP_W'(cmd_d.src_node) < NODES_C) begin
              state <= S_APPEND;
            end
          end
        end
        // Length is back from memory: append or drop
        S_APPEND: begin
          if (len_rdata == FULL) begin
            dropped <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_WALK: begin
          if (walk_stat.done) begin
            total_q <= walk_stat.total;
            state   <= S_EMIT;
          end
        end
        // Hold until the output register is free
        S_EMIT: begin
          if (!res_valid || result.ready) begin
            res_valid               <= 1'b1;
            res_data.triangle_count <= total_q;
            res_data.overflow       <= dropped;
            dropped                 <= 1'b0;
            clr_cnt                 <= '0;
            state                   <= S_CLEAR;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  gtc_ram #(
    .WIDTH(LEN_W),
    .DEPTH(NODES)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .raddr(len_raddr),
    .rdata(len_rdata)
  );

  gtc_ram #(
    .WIDTH(ID_W),
    .DEPTH(NODES * MAX_DEG)
  ) u_adj_ram (
    .clk  (clk),
    .we   (adj_we),
    .waddr(adj_waddr),
    .wdata(dst_q),
    .raddr(walk_adj_raddr),
    .rdata(adj_rdata)
  );

  gtc_walk #(
    .NODES  (NODES),
    .MAX_DEG(MAX_DEG)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .len_rdata(len_rdata),
    .adj_rdata(adj_rdata),
    .len_raddr(walk_len_raddr),
    .adj_raddr(walk_adj_raddr),
    .stat     (walk_stat)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;
  import gtc_pkg::*;

  localparam int NODES        = DEF_NODES;
  localparam int MAX_DEG      = DEF_MAX_DEG;
  localparam int ID_MAX       = (1 << ID_W) - 1;
  localparam int ITEMS_TARGET = 650;
  localparam int DRAIN_LIMIT  = 1000000;

  logic clk;
  logic rst;

  gtc_stream_if #(.T(cmd_t))    cmd_if ();
  gtc_stream_if #(.T(result_t)) res_if ();

  graph_triangle_counter u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .result (res_if)
  );

  // Local copy of the graph: lists, lengths, dropped-entry flag
  logic [ID_W-1:0] adj_mem [NODES][MAX_DEG];
  int unsigned     list_len [NODES];
  bit              drop_seen;

  result_t pending_counts [$];
  int      err_cnt;
  int      items_sent;
  int      counts_checked;
  int      dropped_results;
  int      peak_count;
  int      sink_hold;
  bit      calm;   // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Node id with extra weight on both ends of the range
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_W'($urandom_range(0, ID_MAX));
  endfunction

  function automatic int unsigned deg_of(logic [ID_W-1:0] v);
    if (int'(v) >= NODES) return 0;
    return list_len[v];
  endfunction

  function automatic void append_entry(logic [ID_W-1:0] s, logic [ID_W-1:0] d);
    if (int'(s) >= NODES) return;
    if (list_len[s] < MAX_DEG) begin
      adj_mem[s][list_len[s]] = d;
      list_len[s]++;
    end else begin
      drop_seen = 1'b1;
    end
  endfunction

  // Count closed walks n-a-b-n over the whole graph, then clear all lists
  function automatic result_t count_closed_walks();
    longint          total;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    result_t         r;
    total = 0;
    for (int n = 0; n < NODES; n++) begin
      for (int i = 0; i < int'(list_len[n]); i++) begin
        a = adj_mem[n][i];
        if (int'(a) == n) continue;
        for (int j = 0; j < int'(deg_of(a)); j++) begin
          b = adj_mem[a][j];
          if (int'(b) == n || b == a) continue;
          for (int k = 0; k < int'(deg_of(b)); k++)
            if (int'(adj_mem[b][k]) == n) total++;
        end
      end
      if (total > longint'(CNT_MAX)) total = longint'(CNT_MAX);
    end
    r.triangle_count = total[CNT_W-1:0];
    r.overflow       = drop_seen;
    for (int n = 0; n < NODES; n++) list_len[n] = 0;
    drop_seen = 1'b0;
    return r;
  endfunction

  // Send one item; the graph copy is updated when it is accepted
  task automatic send_cmd(input func_t f, input logic [ID_W-1:0] s,
                          input logic [ID_W-1:0] d);
    int   gap;
    cmd_t c;
    c.func     = f;
    c.src_node = s;
    c.dst_node = d;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk); while (!cmd_if.ready);
    items_sent++;
    if (f == FUNC_COUNT) pending_counts.push_back(count_closed_walks());
    else append_entry(s, d);
  endtask

  task automatic send_count();
    send_cmd(FUNC_COUNT, pick_id(), pick_id());
  endtask

  // Result side: random stalls unless calm
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (sink_hold > 0) begin
      res_if.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      res_if.ready <= 1'b1;
      sink_hold    <= calm ? 0 : pick_gap();
    end
  end

  // Compare each result with the oldest expected count
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result: triangle_count %0d overflow %0b",
               res_if.data.triangle_count, res_if.data.overflow);
        err_cnt++;
      end else begin
        want = pending_counts.pop_front();
        counts_checked++;
        if (want.overflow) dropped_results++;
        if (int'(want.triangle_count) > peak_count) peak_count = int'(want.triangle_count);
        if (res_if.data.triangle_count !== want.triangle_count) begin
          $error("triangle_count mismatch: expected %0d, got %0d",
                 want.triangle_count, res_if.data.triangle_count);
          err_cnt++;
        end
        if (res_if.data.overflow !== want.overflow) begin
          $error("overflow mismatch: expected %0b, got %0b",
                 want.overflow, res_if.data.overflow);
          err_cnt++;
        end
      end
    end
  end

  // Count on an empty graph
  task automatic test_empty_count();
    send_count();
  endtask

  // Undirected triangle on extreme ids, with a self loop and a duplicate edge
  task automatic test_undirected_triangle();
    send_cmd(FUNC_APPEND, 10'd0,   10'd1023);
    send_cmd(FUNC_APPEND, 10'd1023, 10'd0);
    send_cmd(FUNC_APPEND, 10'd1023, 10'd341);
    send_cmd(FUNC_APPEND, 10'd341, 10'd1023);
    send_cmd(FUNC_APPEND, 10'd341, 10'd0);
    send_cmd(FUNC_APPEND, 10'd0,   10'd341);
    send_cmd(FUNC_APPEND, 10'd341, 10'd341);
    send_cmd(FUNC_APPEND, 10'd0,   10'd1023);
    send_count();
  endtask

  // One-way directed triangle 682 -> 5 -> 1000 -> 682, with node 682 on an alternating bit pattern
  task automatic test_directed_cycle();
    send_cmd(FUNC_APPEND, 10'd682,  10'd5);
    send_cmd(FUNC_APPEND, 10'd5,    10'd1000);
    send_cmd(FUNC_APPEND, 10'd1000, 10'd682);
    send_count();
  endtask

  // A list filled exactly to capacity, then one pushed past it
  task automatic test_full_lists();
    logic [ID_W-1:0] hub;
    logic [ID_W-1:0] peer;
    hub  = pick_id();
    peer = pick_id();
    send_cmd(FUNC_APPEND, peer, hub);
    repeat (MAX_DEG - 1) send_cmd(FUNC_APPEND, hub, pick_id());
    send_cmd(FUNC_APPEND, hub, peer);
    send_count();
    hub = pick_id();
    repeat (MAX_DEG + $urandom_range(1, 4)) send_cmd(FUNC_APPEND, hub, pick_id());
    send_count();
    // flag must be clear again after the count
    send_cmd(FUNC_APPEND, hub, pick_id());
    send_count();
  endtask

  // Small random graphs ending in a count; some noise and overfilled lists
  task automatic test_random_graphs();
    logic [ID_W-1:0] grp [8];
    logic [ID_W-1:0] s;
    logic [ID_W-1:0] d;
    int              kind;
    int              nodes;
    int              edges;
    int              hub;
    while (items_sent < ITEMS_TARGET) begin
      calm  = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 99);
      nodes = $urandom_range(3, 8);
      for (int i = 0; i < nodes; i++) grp[i] = pick_id();
      if (kind < 80) begin
        edges = $urandom_range(3, 20);
        hub   = (kind >= 68) ? $urandom_range(0, nodes - 1) : -1;
        for (int e = 0; e < edges; e++) begin
          s = grp[$urandom_range(0, nodes - 1)];
          d = grp[$urandom_range(0, nodes - 1)];
          send_cmd(FUNC_APPEND, s, d);
          if ($urandom_range(0, 2) == 0) send_cmd(FUNC_APPEND, d, s);
        end
        if (hub >= 0)
          repeat (MAX_DEG + $urandom_range(1, 3)) send_cmd(FUNC_APPEND, grp[hub], pick_id());
      end else if (kind < 95) begin
        repeat ($urandom_range(4, 16)) send_cmd(FUNC_APPEND, pick_id(), pick_id());
      end else if (kind < 98) begin
        send_count();
      end
      send_count();
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    rst             = 1'b1;
    cmd_if.valid    = 1'b0;
    cmd_if.data     = '0;
    calm            = 1'b0;
    drop_seen       = 1'b0;
    err_cnt         = 0;
    items_sent      = 0;
    counts_checked  = 0;
    dropped_results = 0;
    peak_count      = 0;
    for (int n = 0; n < NODES; n++) list_len[n] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_count();
    test_undirected_triangle();
    test_directed_cycle();
    test_full_lists();
    test_random_graphs();

    // drain outstanding counts, then let the clear pass finish
    cmd_if.valid <= 1'b0;
    waited = 0;
    while (pending_counts.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (NODES + 64) @(posedge clk);

    if (pending_counts.size() > 0) begin
      $error("%0d expected counts never arrived", pending_counts.size());
      err_cnt++;
    end
    $display("Run covered %0d items and %0d count results (%0d with dropped entries).",
             items_sent, counts_checked, dropped_results);
    $display("Largest walk count seen: %0d.", peak_count);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
